// ===== rtl/tt_pkg.sv =====
// ----------------------------------------------------------------------------
// tt_pkg
// Shared types and constants for the trimmed-mean period tachometer.
// ----------------------------------------------------------------------------
package tt_pkg;

  localparam int unsigned FREQ_SCALE      = 1000000;
  localparam logic [15:0] MAX_FREQ_RESET  = 16'd780;
  localparam logic [15:0] LAST_GOOD_RESET = 16'd150;
  localparam int unsigned FIFO_DEPTH      = 2;

  typedef enum logic {
    OP_EDGE   = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_FRESH  = 2'd0,
    STAT_HELD   = 2'd1,
    STAT_NODATA = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_MUL,
    ST_MEAN,
    ST_FREQ,
    ST_DONE
  } state_t;

  // queued work: operation plus period since the previous edge
  typedef struct packed {
    op_t         op;
    logic [31:0] period;
  } q_entry_t;

endpackage

// ===== rtl/tt_if.sv =====
// ----------------------------------------------------------------------------
// tt_if
// Valid/ready channel interfaces for tachometer events and reports.
// ----------------------------------------------------------------------------
interface tt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] timestamp_us;

  modport source (output valid, output operation, output timestamp_us, input ready);
  modport sink   (input valid, input operation, input timestamp_us, output ready);
endinterface

interface tt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] frequency;
  logic [1:0]  status;

  modport source (output valid, output frequency, output status, input ready);
  modport sink   (input valid, input frequency, input status, output ready);
endinterface

// ===== rtl/tt_front.sv =====
// ----------------------------------------------------------------------------
// tt_front
// Accepts events, computes the edge-to-edge period and queues the work.
// ----------------------------------------------------------------------------
module tt_front (
  input  logic             clk,
  input  logic             rst_n,
  tt_in_if.sink            in_chan,
  input  logic             q_full,
  output logic             push,
  output tt_pkg::q_entry_t push_data
);
  import tt_pkg::*;

  logic [31:0] last_edge_r;
  logic [31:0] last_edge_nxt;
  op_t         op;

  assign op            = op_t'(in_chan.operation);
  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && in_chan.ready;

  // period wraps modulo 2^32
  assign push_data = '{op: op, period: in_chan.timestamp_us - last_edge_r};

  always_comb begin
    last_edge_nxt = last_edge_r;
    if (push && op == OP_EDGE) begin
      last_edge_nxt = in_chan.timestamp_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
    end else begin
      last_edge_r <= last_edge_nxt;
    end
  end

endmodule

// ===== rtl/tt_fifo.sv =====
// ----------------------------------------------------------------------------
// tt_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module tt_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tt_pkg::q_entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output tt_pkg::q_entry_t q_data
);
  import tt_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  q_entry_t        mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(FIFO_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/tt_div.sv =====
// ----------------------------------------------------------------------------
// tt_div
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// ----------------------------------------------------------------------------
module tt_div #(
  parameter int DW = 35
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import tt_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r;
  logic [31:0]   rem_r;
  logic [31:0]   dsr_r;
  logic [32:0]   shifted;
  logic [33:0]   diff;
  logic          ge;

  assign shifted  = {rem_r, quo_r[DW-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dsr_r};
  assign ge       = !diff[33];
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : shifted[31:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/tt_back.sv =====
// ----------------------------------------------------------------------------
// tt_back
// Executes queued work: ring update on edges, trimmed mean and frequency on
// reports, result held in an output register.
// ----------------------------------------------------------------------------
module tt_back #(
  parameter int WINDOW = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tt_pkg::q_entry_t q_data,
  output logic             q_pop,
  input  logic [15:0]      max_freq,
  tt_out_if.source         out_chan
);
  import tt_pkg::*;

  localparam int IW  = $clog2(WINDOW);
  localparam int SW  = 32 + $clog2(WINDOW);
  // divide by WINDOW-2 as a multiply by ceil(2^RS / (WINDOW-2)); the rounding
  // error times any SW-bit dividend stays below 2^RS, so the quotient is exact
  localparam int DV  = WINDOW - 2;
  localparam int RS  = SW + 4;
  localparam int MW  = RS + 1;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RS) + 64'(DV - 1)) / 64'(DV));
  localparam int CH  = 12;
  localparam int NCH = (SW + CH - 1) / CH;
  localparam int XW  = NCH * CH;
  localparam int PW  = XW + MW;
  localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;

  state_t        state_r, state_nxt;
  logic [31:0]   ring_r [WINDOW];
  logic [IW-1:0] idx_r;
  logic [IW-1:0] k_r;
  logic [SW-1:0] sum_r;
  logic [31:0]   lo_r, hi_r;
  logic [XW-1:0] mul_x_r;
  logic [PW-1:0] acc_r;
  logic [KW-1:0] mul_k_r;
  logic [15:0]   last_good_r;
  logic [15:0]   res_freq_r;
  status_t       res_stat_r;
  logic          out_valid_r;
  logic [15:0]   out_freq_r;
  status_t       out_stat_r;

  logic             scan_last;
  logic [31:0]      cur;
  logic [SW-1:0]    trimmed;
  logic [CH+MW-1:0] part;
  logic             mul_last;
  logic [31:0]      mean;
  logic             div_start;
  logic [SW-1:0]    div_dividend;
  logic [31:0]      div_divisor;
  logic             div_done;
  logic [SW-1:0]    div_quot;
  logic             mean_zero;
  logic             fresh;
  logic             load_out;

  assign cur       = ring_r[k_r];
  assign scan_last = (k_r == IW'(WINDOW - 1));
  assign trimmed   = sum_r - SW'(lo_r) - SW'(hi_r);
  // multiplier digits go in most significant chunk first
  assign part      = {{MW{1'b0}}, mul_x_r[XW-1 -: CH]} * RECIP;
  assign mul_last  = (mul_k_r == KW'(NCH - 1));
  assign mean      = acc_r[RS +: 32];
  assign mean_zero = (mean == '0);
  assign fresh     = (div_quot < SW'(max_freq));

  assign div_dividend = SW'(FREQ_SCALE);
  assign div_divisor  = mean;

  tt_div #(.DW(SW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid && q_data.op == OP_REPORT) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_last) state_nxt = ST_TRIM;
      ST_TRIM: state_nxt = ST_MUL;
      ST_MUL:  if (mul_last) state_nxt = ST_MEAN;
      ST_MEAN: state_nxt = mean_zero ? ST_DONE : ST_FREQ;
      ST_FREQ: if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: q_pop = q_valid;
      ST_MEAN: div_start = !mean_zero;
      ST_DONE: load_out = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) ring_r[i] <= '0;
      idx_r       <= '0;
      last_good_r <= LAST_GOOD_RESET;
    end else begin
      if (state_r == ST_IDLE && q_valid && q_data.op == OP_EDGE) begin
        ring_r[idx_r] <= q_data.period;
        idx_r         <= (idx_r == IW'(WINDOW - 1)) ? '0 : idx_r + 1'b1;
      end
      if (state_r == ST_FREQ && div_done && fresh) begin
        last_good_r <= div_quot[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: k_r <= '0;
      ST_SCAN: begin
        k_r <= k_r + 1'b1;
        if (k_r == '0) begin
          sum_r <= SW'(cur);
          lo_r  <= cur;
          hi_r  <= cur;
        end else begin
          sum_r <= sum_r + SW'(cur);
          if (cur < lo_r) lo_r <= cur;
          if (cur > hi_r) hi_r <= cur;
        end
      end
      ST_TRIM: begin
        mul_x_r <= XW'(trimmed);
        acc_r   <= '0;
        mul_k_r <= '0;
      end
      ST_MUL: begin
        acc_r   <= {acc_r[PW-CH-1:0], {CH{1'b0}}} + PW'(part);
        mul_x_r <= {mul_x_r[XW-CH-1:0], {CH{1'b0}}};
        mul_k_r <= mul_k_r + 1'b1;
      end
      ST_MEAN: begin
        if (mean_zero) begin
          res_freq_r <= '0;
          res_stat_r <= STAT_NODATA;
        end
      end
      ST_FREQ: begin
        if (div_done) begin
          res_freq_r <= fresh ? div_quot[15:0] : last_good_r;
          res_stat_r <= fresh ? STAT_FRESH : STAT_HELD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_freq_r <= res_freq_r;
      out_stat_r <= res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.frequency = out_freq_r;
  assign out_chan.status    = out_stat_r;

endmodule

// ===== rtl/tachometer_trimmed_mean_freq.sv =====
// ----------------------------------------------------------------------------
// tachometer_trimmed_mean_freq
// Trimmed-mean period tachometer with a queued front end and divider back end.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries edge events (operation 0, with a microsecond timestamp) and
//   report requests (operation 1). Edges produce no result; each report produces
//   one transaction on out_chan with frequency and status.
//   cfg_we/cfg_wdata write max_freq; write only while the block is idle.
// Sequence:
//   An edge is registered into the queue when accepted and retires when the idle
//   back end pops it into the period ring. A report runs through these steps
//   before out_chan.valid rises: pop, a ring scan over WINDOW entries, a trim
//   step, a chunked reciprocal multiply for the divide by WINDOW-2, a mean test,
//   the bit-serial 1000000 / mean divider (32 + clog2(WINDOW) bits wide, skipped
//   when the mean is zero) and the output load. Reports go through one at a
//   time; a two-entry queue takes up to two more events meanwhile.
// Reset:
//   rst_n (synchronous, active low) zeroes the period ring, ring index and last
//   edge time, sets last good frequency to 150 and max_freq to 780.
// Backpressure:
//   A result waits in the output register while out_chan is stalled; the next
//   report finishes and holds, then the queue fills and in_chan.ready drops.
// ----------------------------------------------------------------------------
module tachometer_trimmed_mean_freq #(
  parameter int WINDOW = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  tt_in_if.sink       in_chan,
  tt_out_if.source    out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import tt_pkg::*;

  logic [15:0] max_freq_q_r, max_freq_nxt;
  logic        push, q_full, q_pop, q_valid;
  q_entry_t    push_data, q_data;

  always_comb begin
    max_freq_nxt = cfg_we ? cfg_wdata : max_freq_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_freq_q_r <= MAX_FREQ_RESET;
    end else begin
      max_freq_q_r <= max_freq_nxt;
    end
  end

  tt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  tt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  tt_back #(.WINDOW(WINDOW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .max_freq (max_freq_q_r),
    .out_chan (out_chan)
  );

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> max_freq_q_r == $past(cfg_wdata))
    else $error("max_freq register did not take the write");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> q_valid)
    else $error("input stalled with an empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

endmodule
